/* sv/fmmac_pkg.sv */
// ----------------------------------------------------------------------------
// fmmac_pkg
// Shared types, constants and helpers of the fp32 matrix multiply-accumulate
// unit: default store sizes, item and register codes, binary32 constants.
// ----------------------------------------------------------------------------
package fmmac_pkg;

	// Default store sizes
	localparam int DEF_MAX_ROWS  = 128;
	localparam int DEF_MAX_DEPTH = 256;
	localparam int DEF_MAX_COLS  = 128;
	localparam int PANEL         = 32;

	// Item function codes
	localparam logic [2:0] FN_WR_A = 3'd0;
	localparam logic [2:0] FN_WR_B = 3'd1;
	localparam logic [2:0] FN_WR_C = 3'd2;
	localparam logic [2:0] FN_RUN  = 3'd3;
	localparam logic [2:0] FN_RD_C = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_M_ROWS   = 2'd0;
	localparam logic [1:0] CFG_K_DEPTH  = 2'd1;
	localparam logic [1:0] CFG_N_PANELS = 2'd2;

	// Register reset values
	localparam logic [7:0] RST_M_ROWS   = 8'd128;
	localparam logic [8:0] RST_K_DEPTH  = 9'd192;
	localparam logic [2:0] RST_N_PANELS = 3'd2;

	// Exponent of the weight of bit zero, signed
	typedef logic signed [11:0] exp_t;

	localparam exp_t       EXP_BIAS   = 12'sd150;
	localparam exp_t       EXP_TINY   = -12'sd149;
	localparam exp_t       RND_SHIFT  = 12'sd38;
	localparam exp_t       EXP_TOP    = 12'sd255;
	localparam logic [31:0] QNAN_DEF  = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

	// Address bits for a store of the given depth
	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

/* sv/fmmac_ram.sv */
// ----------------------------------------------------------------------------
// fmmac_ram
// Single-clock store with one write port and one read port; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
module fmmac_ram
	import fmmac_pkg::*;
#(
	parameter int DEPTH = 2,
	localparam int AW = addr_bits(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/fmmac_fma.sv */
// ----------------------------------------------------------------------------
// fmmac_fma
// Multi-cycle binary32 fused multiply-add, result = x * y + z with a single
// round to nearest even. Multiply, normalize, align, add, normalize, round.
// ----------------------------------------------------------------------------
module fmmac_fma
	import fmmac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	input  logic [31:0] y,
	input  logic [31:0] z,
	output logic        busy,
	output logic        done,
	output logic [31:0] result
);

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_NORM  = 3'd1;
	localparam logic [2:0] F_ALIGN = 3'd2;
	localparam logic [2:0] F_ADD   = 3'd3;
	localparam logic [2:0] F_RNORM = 3'd4;
	localparam logic [2:0] F_RND1  = 3'd5;
	localparam logic [2:0] F_RND2  = 3'd6;
	localparam logic [2:0] F_DONE  = 3'd7;

	logic [2:0]  fst_q;
	logic [63:0] p_q, mz_q;
	exp_t        ep_q, ez_q;
	logic        sp_q, sz_q, zz_q;
	logic [23:0] q_q;
	logic        inc_q;
	logic [31:0] res_q;

	// Operand decode
	logic        sx, sy, sz, sp;
	logic        xinf, yinf, zinf, xnan, ynan, znan, xz, yz, zz;
	logic [23:0] mx, my, mz;
	exp_t        exx, exy, exz;
	logic        spec;
	logic [31:0] sres;
	logic [47:0] prod;

	always_comb begin
		sx   = x[31];
		sy   = y[31];
		sz   = z[31];
		sp   = sx ^ sy;
		xinf = &x[30:23];
		yinf = &y[30:23];
		zinf = &z[30:23];
		xnan = xinf && (|x[22:0]);
		ynan = yinf && (|y[22:0]);
		znan = zinf && (|z[22:0]);
		xz   = (x[30:0] == 31'd0);
		yz   = (y[30:0] == 31'd0);
		zz   = (z[30:0] == 31'd0);
		mx   = {(x[30:23] != 8'd0), x[22:0]};
		my   = {(y[30:23] != 8'd0), y[22:0]};
		mz   = {(z[30:23] != 8'd0), z[22:0]};
		exx  = exp_t'({4'd0, (x[30:23] != 8'd0) ? x[30:23] : 8'd1}) - EXP_BIAS;
		exy  = exp_t'({4'd0, (y[30:23] != 8'd0) ? y[30:23] : 8'd1}) - EXP_BIAS;
		exz  = exp_t'({4'd0, (z[30:23] != 8'd0) ? z[30:23] : 8'd1}) - EXP_BIAS;
	end

	// Full 48-bit significand product
	assign prod = mx * my;

	// Special operands: NaN, infinity, zero product
	always_comb begin
		spec = 1'b1;
		sres = '0;
		if (xnan) begin
			sres = x | QUIET_BIT;
		end else if (ynan) begin
			sres = y | QUIET_BIT;
		end else if (znan) begin
			sres = z | QUIET_BIT;
		end else if (xinf || yinf) begin
			if ((xinf && yz) || (yinf && xz)) begin
				sres = QNAN_DEF;
			end else if (zinf && (sz != sp)) begin
				sres = QNAN_DEF;
			end else begin
				sres = {sp, 8'hFF, 23'd0};
			end
		end else if (zinf) begin
			sres = z;
		end else if (xz || yz) begin
			sres = zz ? {sp & sz, 31'd0} : z;
		end else begin
			spec = 1'b0;
		end
	end

	// Alignment of the smaller term
	logic        p_big;
	logic [63:0] big, sml, sml_sh, lost_mask;
	exp_t        eb, d;
	logic        sb, ss;

	always_comb begin
		p_big = (ep_q > ez_q) || ((ep_q == ez_q) && (p_q >= mz_q));
		big   = p_big ? p_q : mz_q;
		sml   = p_big ? mz_q : p_q;
		eb    = p_big ? ep_q : ez_q;
		sb    = p_big ? sp_q : sz_q;
		ss    = p_big ? sz_q : sp_q;
		d     = p_big ? (ep_q - ez_q) : (ez_q - ep_q);
		lost_mask = ~({64{1'b1}} << d[5:0]);
		if (d >= 12'sd64) begin
			sml_sh = 64'd1;
		end else if (d > 12'sd0) begin
			sml_sh = (sml >> d[5:0]) | {63'd0, |(sml & lost_mask)};
		end else begin
			sml_sh = sml;
		end
	end

	// Add or subtract magnitudes
	logic [63:0] sum;

	assign sum = (sp_q == sz_q) ? (p_q + mz_q) : (p_q - mz_q);

	// Rounding position and guard, sticky
	exp_t        t_exp, s_exp, s_m1;
	logic [63:0] r_sh, st_mask;
	logic        guard, sticky;

	always_comb begin
		t_exp   = EXP_TINY - ep_q;
		s_exp   = (t_exp > RND_SHIFT) ? t_exp : RND_SHIFT;
		s_m1    = s_exp - 12'sd1;
		r_sh    = p_q >> s_m1[5:0];
		st_mask = ~({64{1'b1}} << s_m1[5:0]);
		guard   = r_sh[0];
		sticky  = |(p_q & st_mask);
	end

	// Increment and pack
	logic [24:0] qi;
	logic [23:0] qn;
	exp_t        e1, be;
	logic [31:0] packed_res;

	always_comb begin
		qi = {1'b0, q_q} + {24'd0, inc_q};
		if (qi[24]) begin
			qn = qi[24:1];
			e1 = ep_q + 12'sd1;
		end else begin
			qn = qi[23:0];
			e1 = ep_q;
		end
		be = e1 + EXP_BIAS;
		if (qn[23]) begin
			if (be >= EXP_TOP) begin
				packed_res = {sp_q, 8'hFF, 23'd0};
			end else begin
				packed_res = {sp_q, be[7:0], qn[22:0]};
			end
		end else begin
			packed_res = {sp_q, 8'd0, qn[22:0]};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			unique case (fst_q)
				F_IDLE: begin
					if (start) begin
						fst_q <= spec ? F_DONE : F_NORM;
					end
				end
				F_NORM: begin
					if (p_q[61] && (zz_q || mz_q[61])) begin
						fst_q <= zz_q ? F_RND1 : F_ALIGN;
					end
				end
				F_ALIGN: fst_q <= F_ADD;
				F_ADD: begin
					if (sum == 64'd0) begin
						fst_q <= F_DONE;
					end else if (sum[62]) begin
						fst_q <= F_RND1;
					end else begin
						fst_q <= F_RNORM;
					end
				end
				F_RNORM: begin
					if (p_q[61]) begin
						fst_q <= F_RND1;
					end
				end
				F_RND1: fst_q <= (s_exp >= 12'sd64) ? F_DONE : F_RND2;
				F_RND2: fst_q <= F_DONE;
				F_DONE: fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: begin
				if (start) begin
					res_q <= sres;
					p_q   <= {16'd0, prod};
					ep_q  <= exx + exy;
					mz_q  <= {40'd0, mz};
					ez_q  <= exz;
					sp_q  <= sp;
					sz_q  <= sz;
					zz_q  <= zz;
				end
			end
			F_NORM, F_RNORM: begin
				if (!p_q[61]) begin
					if (p_q[61:54] == 8'd0) begin
						p_q  <= p_q << 8;
						ep_q <= ep_q - 12'sd8;
					end else begin
						p_q  <= p_q << 1;
						ep_q <= ep_q - 12'sd1;
					end
				end
				if (fst_q == F_NORM && !zz_q && !mz_q[61]) begin
					if (mz_q[61:54] == 8'd0) begin
						mz_q <= mz_q << 8;
						ez_q <= ez_q - 12'sd8;
					end else begin
						mz_q <= mz_q << 1;
						ez_q <= ez_q - 12'sd1;
					end
				end
			end
			F_ALIGN: begin
				p_q  <= big;
				mz_q <= sml_sh;
				ep_q <= eb;
				sp_q <= sb;
				sz_q <= ss;
			end
			F_ADD: begin
				if (sum == 64'd0) begin
					res_q <= 32'd0;
				end else if (sum[62]) begin
					p_q  <= {1'b0, sum[63:1]} | {63'd0, sum[0]};
					ep_q <= ep_q + 12'sd1;
				end else begin
					p_q <= sum;
				end
			end
			F_RND1: begin
				res_q <= {sp_q, 31'd0};
				q_q   <= r_sh[24:1];
				inc_q <= guard && (sticky || r_sh[1]);
				ep_q  <= ep_q + s_exp;
			end
			F_RND2: res_q <= packed_res;
			default: begin
			end
		endcase
	end

	assign busy   = (fst_q != F_IDLE);
	assign done   = (fst_q == F_DONE);
	assign result = res_q;

endmodule

/* sv/fp32_matrix_multiply_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// fp32_matrix_multiply_accumulate_unit
// Binary32 C += A * B engine with loadable A, B and C stores.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel: tuser carries the function (write A,
//   write B, write C, run, read C), tdata carries row, column and value.
//   Every item returns exactly one result on m_axis: the C element for a
//   read, zero otherwise, with tuser[0] flagging an out-of-range index.
//   Sizes are set through the cfg channel (rows, depth, 32-column panels)
//   and are taken only while no item is in flight.
//   Writes and out-of-range items answer in the cycle after the transfer;
//   a read answers after the store read and the output register. A run
//   answers when the whole update is finished: each C element takes one C
//   read, and each step of k a store read plus one pass of the fused
//   multiply-add unit, whose length is set by its normalize loops. No item
//   is taken during a run. Reset returns control and sizes to their reset
//   values only; store contents are undefined until written. When m_axis
//   stalls, the result holds in the output register and s_axis takes the
//   next item as soon as that register frees.
// ----------------------------------------------------------------------------
module fp32_matrix_multiply_accumulate_unit
	import fmmac_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // row[7:0], col[15:8], value[47:16]
	input  logic [2:0]  s_axis_tuser,   // func[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // read_value[31:0]
	output logic [0:0]  m_axis_tuser,   // index_error[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
	localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AAW = addr_bits(A_DEPTH);
	localparam int BAW = addr_bits(B_DEPTH);
	localparam int CAW = addr_bits(C_DEPTH);
	localparam int MAX_PANELS = MAX_COLS / PANEL;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_GO   = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;

	logic [2:0]  state_q;
	logic [7:0]  m_rows_q;
	logic [8:0]  k_depth_q;
	logic [2:0]  n_panels_q;
	logic [7:0]  i_q, j_q;
	logic [8:0]  k_q;
	logic [31:0] acc_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_err_q;

	// Item fields
	logic [2:0]  func;
	logic [7:0]  row, col;
	logic [31:0] value;

	assign func  = s_axis_tuser;
	assign row   = s_axis_tdata[7:0];
	assign col   = s_axis_tdata[15:8];
	assign value = s_axis_tdata[47:16];

	// Effective sizes
	logic [7:0] m_eff, nc_eff;
	logic [8:0] kd_eff;
	logic [2:0] p_eff;

	assign m_eff  = (32'(m_rows_q) < MAX_ROWS) ? m_rows_q : 8'(MAX_ROWS);
	assign kd_eff = (32'(k_depth_q) < MAX_DEPTH) ? k_depth_q : 9'(MAX_DEPTH);
	assign p_eff  = (32'(n_panels_q) < MAX_PANELS) ? n_panels_q : 3'(MAX_PANELS);
	assign nc_eff = {p_eff, 5'd0};

	// Handshakes
	logic in_xfer, out_take;

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;
	assign cfg_ready     = (state_q == ST_IDLE);

	// Range checks
	logic a_ok, b_ok, c_ok;

	assign a_ok = (row < m_eff) && ({1'b0, col} < kd_eff);
	assign b_ok = ({1'b0, row} < kd_eff) && (col < nc_eff);
	assign c_ok = (row < m_eff) && (col < nc_eff);

	// Store ports
	logic            a_we, a_re, b_we, b_re, c_we, c_re;
	logic [AAW-1:0]  a_waddr, a_raddr;
	logic [BAW-1:0]  b_waddr, b_raddr;
	logic [CAW-1:0]  c_waddr, c_raddr;
	logic [31:0]     c_wdata, a_rdata, b_rdata, c_rdata, fma_res;
	logic [8:0]      k_nx, k_sel;
	logic [7:0]      c_row, c_col;

	assign k_nx    = k_q + 9'd1;
	assign k_sel   = (state_q == ST_LOAD) ? k_q : k_nx;
	assign c_row   = (state_q == ST_IDLE) ? row : i_q;
	assign c_col   = (state_q == ST_IDLE) ? col : j_q;
	assign a_waddr = AAW'(32'(row) * MAX_DEPTH + 32'(col));
	assign a_raddr = AAW'(32'(i_q) * MAX_DEPTH + 32'(k_sel));
	assign b_waddr = BAW'(32'(row) * MAX_COLS + 32'(col));
	assign b_raddr = BAW'(32'(k_sel) * MAX_COLS + 32'(j_q));
	assign c_waddr = CAW'(32'(c_row) * MAX_COLS + 32'(c_col));
	assign c_raddr = c_waddr;
	assign c_wdata = (state_q == ST_IDLE) ? value : fma_res;

	// Multiply-add unit hookup
	logic        fma_start, fma_busy, fma_done;
	logic [31:0] fma_z;

	assign fma_start = (state_q == ST_GO);
	assign fma_z     = (k_q == 9'd0) ? c_rdata : acc_q;

	// Run sequencing
	logic k_last, j_last, i_last;

	assign k_last = (k_q == kd_eff - 9'd1);
	assign j_last = (j_q == nc_eff - 8'd1);
	assign i_last = (i_q == m_eff - 8'd1);

	// Decode items and steer store accesses
	logic        out_load;
	logic [31:0] out_data_d;
	logic        out_err_d;
	logic [2:0]  state_d;

	always_comb begin
		a_we       = 1'b0;
		b_we       = 1'b0;
		c_we       = 1'b0;
		a_re       = 1'b0;
		b_re       = 1'b0;
		c_re       = 1'b0;
		out_load   = 1'b0;
		out_data_d = 32'd0;
		out_err_d  = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (func)
						FN_WR_A: begin
							a_we      = a_ok;
							out_load  = 1'b1;
							out_err_d = !a_ok;
						end
						FN_WR_B: begin
							b_we      = b_ok;
							out_load  = 1'b1;
							out_err_d = !b_ok;
						end
						FN_WR_C: begin
							c_we      = c_ok;
							out_load  = 1'b1;
							out_err_d = !c_ok;
						end
						FN_RUN: begin
							if (m_eff == 8'd0 || nc_eff == 8'd0 || kd_eff == 9'd0) begin
								out_load = 1'b1;
							end else begin
								state_d = ST_LOAD;
							end
						end
						FN_RD_C: begin
							if (c_ok) begin
								c_re    = 1'b1;
								state_d = ST_READ;
							end else begin
								out_load  = 1'b1;
								out_err_d = 1'b1;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_load   = 1'b1;
				out_data_d = c_rdata;
				state_d    = ST_IDLE;
			end
			ST_LOAD: begin
				a_re    = 1'b1;
				b_re    = 1'b1;
				c_re    = 1'b1;
				state_d = ST_GO;
			end
			ST_GO: state_d = ST_WAIT;
			ST_WAIT: begin
				if (fma_done) begin
					if (k_last) begin
						c_we = 1'b1;
						if (j_last && i_last) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end else begin
							state_d = ST_LOAD;
						end
					end else begin
						a_re    = 1'b1;
						b_re    = 1'b1;
						state_d = ST_GO;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, counters and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			m_rows_q    <= RST_M_ROWS;
			k_depth_q   <= RST_K_DEPTH;
			n_panels_q  <= RST_N_PANELS;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_M_ROWS:   m_rows_q   <= cfg_data[7:0];
					CFG_K_DEPTH:  k_depth_q  <= cfg_data;
					CFG_N_PANELS: n_panels_q <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			// Advance k, then j, then i
			if (state_q == ST_IDLE && in_xfer) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_WAIT && fma_done) begin
				if (k_last) begin
					k_q <= '0;
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 8'd1;
					end else begin
						j_q <= j_q + 8'd1;
					end
				end else begin
					k_q <= k_nx;
				end
			end
		end
	end

	// Output payload and accumulator
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_err_q  <= out_err_d;
		end
		if (state_q == ST_WAIT && fma_done) begin
			acc_q <= fma_res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_err_q;

	fmmac_ram #(.DEPTH(A_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (value),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	fmmac_ram #(.DEPTH(B_DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (value),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	fmmac_ram #(.DEPTH(C_DEPTH)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	fmmac_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fma_start),
		.x      (b_rdata),
		.y      (a_rdata),
		.z      (fma_z),
		.busy   (fma_busy),
		.done   (fma_done),
		.result (fma_res)
	);

`ifndef SYNTHESIS
	// Run counters stay inside the configured sizes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_GO || state_q == ST_WAIT) |->
		(i_q < m_eff && j_q < nc_eff && k_q < kd_eff))
		else $error("run index outside configured sizes");

	// A run writes C back only when the last step of k completes
	assert property (@(posedge clk) disable iff (!arst_n)
		(c_we && state_q == ST_WAIT) |-> (fma_done && k_last))
		else $error("C written back before the k chain completed");

	// No item is taken while the multiply-add unit is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !fma_busy)
		else $error("item transfer during multiply-add");

	// Every multiply-add start comes in the cycle after its operand reads
	assert property (@(posedge clk) disable iff (!arst_n)
		fma_start |-> $past(a_re && b_re))
		else $error("multiply-add started without operand read");
`endif

endmodule
